FILE: hw/rtl/alss_pkg.sv
package alss_pkg;

	localparam int SLOTS  = 32;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TAG_W  = 16;
	localparam int TIME_W = 63;
	localparam int ID_W   = 21;

	localparam logic [TIME_W-1:0] MAX63 = {TIME_W{1'b1}};
	localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

	localparam logic [2:0] CMD_ADD_ALARM  = 3'd0;
	localparam logic [2:0] CMD_ADD_REP    = 3'd1;
	localparam logic [2:0] CMD_CANCEL_AL  = 3'd2;
	localparam logic [2:0] CMD_CANCEL_REP = 3'd3;
	localparam logic [2:0] CMD_TICK       = 3'd4;
	localparam logic [2:0] CMD_COMPLETE   = 3'd5;

	typedef enum logic [1:0] {PH_FREE, PH_ARMED, PH_FIRING} phase_t;

	typedef enum logic [2:0] {OP_IDLE, OP_LOAD, OP_ADD, OP_TICK, OP_TEND, OP_ONE} op_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	typedef struct packed {
		logic scan_last;
		logic add_hit;
	} sts_t;

	// base + signed d, clamped into [0, MAX63]
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] base,
		input logic [63:0] d);
		logic signed [64:0] s;
		s = $signed({2'b00, base}) + $signed({d[63], d});
		if (s[64])
			return '0;
		else if (s[63])
			return MAX63;
		else
			return s[62:0];
	endfunction

	// |d| clamped to MAX63, zero becomes one
	function automatic logic [TIME_W-1:0] magnitude(input logic [63:0] d);
		logic [63:0] m;
		m = d[63] ? (~d + 64'd1) : d;
		if (m[63])
			return MAX63;
		else if (m == 64'd0)
			return {{(TIME_W-1){1'b0}}, 1'b1};
		else
			return m[62:0];
	endfunction

endpackage

FILE: hw/rtl/alss_ctrl.sv
module alss_ctrl
	import alss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] cmd,
	input  sts_t       sts,
	output ctl_t       ctl,
	output logic       busy
);

	typedef enum logic [2:0] {S_IDLE, S_ADD, S_TICK, S_TEND, S_ONE} state_t;

	state_t state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		unique case (state_q)
			S_IDLE: ctl.op = start ? OP_LOAD : OP_IDLE;
			S_ADD:  ctl.op = OP_ADD;
			S_TICK: ctl.op = OP_TICK;
			S_TEND: ctl.op = OP_TEND;
			S_ONE:  ctl.op = OP_ONE;
			default: ctl.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd == CMD_ADD_ALARM || cmd == CMD_ADD_REP)
							state_q <= S_ADD;
						else if (cmd == CMD_TICK)
							state_q <= S_TICK;
						else
							state_q <= S_ONE;
					end
				end
				S_ADD: begin
					if (sts.add_hit || sts.scan_last)
						state_q <= S_IDLE;
				end
				S_TICK: begin
					if (sts.scan_last)
						state_q <= S_TEND;
				end
				S_TEND: state_q <= S_IDLE;
				S_ONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_tend_ret: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TEND |=> state_q == S_IDLE) else $error("tick end did not return");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !start) |=> state_q == S_IDLE) else $error("left idle");
	a_one_ret: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ONE |=> state_q == S_IDLE) else $error("single op did not return");

endmodule

FILE: hw/rtl/alss_dp.sv
module alss_dp
	import alss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	output sts_t              sts,
	input  logic [2:0]        cmd,
	input  logic [TIME_W-1:0] now_us,
	input  logic [63:0]       lead_time,
	input  logic [ID_W-1:0]   timer_ref,
	input  logic              keep_going,
	input  logic [63:0]       reschedule_delta,
	output logic              done,
	output logic              ok,
	output logic [ID_W-1:0]   result_id,
	output logic              fired_repeating,
	output logic [TIME_W-1:0] fire_time,
	output logic              have_deadline,
	output logic [TIME_W-1:0] next_deadline_us,
	output logic              last
);

	phase_t            phase_q [SLOTS];
	logic              rep_q   [SLOTS];
	logic              cp_q    [SLOTS];
	logic [TAG_W-1:0]  gen_q   [SLOTS];
	logic [TIME_W-1:0] tgt_q   [SLOTS];
	logic [TIME_W-1:0] per_q   [SLOTS];
	logic [TAG_W-1:0]  tag_q;

	logic [2:0]        cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [63:0]       delay_q;
	logic [ID_W-1:0]   id_q;
	logic              keep_q;
	logic [63:0]       delta_q;
	logic [TIME_W-1:0] mag_q;

	logic [IDX_W-1:0]  scan_q;
	logic              pend_v_q;
	logic [ID_W-1:0]   pend_id_q;
	logic              pend_rep_q;
	logic [TIME_W-1:0] pend_tgt_q;
	logic              have_q;
	logic [TIME_W-1:0] early_q;

	logic [IDX_W-1:0]  ai;
	phase_t            c_ph;
	logic              c_rep, c_cp;
	logic [TAG_W-1:0]  c_gen;
	logic [TIME_W-1:0] c_tgt, c_per;
	logic              id_ok, gen_ok, neg, due, earlier, cancel_hit, comp_hit, comp_keep;
	logic              alloc;
	logic [TIME_W-1:0] add_tgt, comp_tgt;
	logic              emit, e_ok, e_rep, e_hd, e_last;
	logic [ID_W-1:0]   e_id;
	logic [TIME_W-1:0] e_tgt, e_nd;

	always_comb begin
		ai     = (ctl.op == OP_ONE) ? id_q[16 +: IDX_W] : scan_q;
		c_ph   = phase_q[ai];
		c_rep  = rep_q[ai];
		c_cp   = cp_q[ai];
		c_gen  = gen_q[ai];
		c_tgt  = tgt_q[ai];
		c_per  = per_q[ai];
		id_ok  = {1'b0, id_q[ID_W-1:16]} < 6'(SLOTS);
		gen_ok = (c_gen == id_q[TAG_W-1:0]);
		neg    = delta_q[63];
		alloc  = (ctl.op == OP_ADD) && (c_ph == PH_FREE);
		add_tgt = sat_add(now_q, (cmd_q == CMD_ADD_REP) ? {1'b0, mag_q} : delay_q);
		comp_tgt = sat_add((c_rep || neg) ? c_tgt : now_q,
			c_rep ? {1'b0, c_per} : (neg ? {1'b0, mag_q} : delta_q));
		comp_keep  = c_rep ? keep_q : (delta_q != 64'd0);
		due        = (c_ph == PH_ARMED) && (c_tgt <= now_q);
		earlier    = (c_ph == PH_ARMED) && (!have_q || c_tgt < early_q);
		cancel_hit = id_ok && gen_ok && (c_rep == (cmd_q == CMD_CANCEL_REP)) &&
			(c_ph == PH_ARMED || c_ph == PH_FIRING);
		comp_hit   = id_ok && gen_ok && (c_ph == PH_FIRING);

		sts.scan_last = (scan_q == IDX_W'(SLOTS - 1));
		sts.add_hit   = (c_ph == PH_FREE);

		emit = 1'b0; e_ok = 1'b0; e_id = '0; e_rep = 1'b0; e_tgt = '0;
		e_hd = 1'b0; e_nd = '0; e_last = 1'b1;
		unique case (ctl.op)
			OP_ADD: begin
				if (alloc) begin
					emit = 1'b1; e_ok = 1'b1; e_id = ID_W'({ai, tag_q});
				end else if (sts.scan_last) begin
					emit = 1'b1;
				end
			end
			OP_TICK: begin
				if (due && pend_v_q) begin
					emit = 1'b1; e_ok = 1'b1; e_id = pend_id_q; e_rep = pend_rep_q;
					e_tgt = pend_tgt_q; e_last = 1'b0;
				end
			end
			OP_TEND: begin
				emit = 1'b1;
				if (pend_v_q) begin
					e_ok = 1'b1; e_id = pend_id_q; e_rep = pend_rep_q; e_tgt = pend_tgt_q;
				end else begin
					e_hd = have_q; e_nd = have_q ? early_q : '0;
				end
			end
			OP_ONE: begin
				emit = 1'b1;
				if (cmd_q == CMD_CANCEL_AL || cmd_q == CMD_CANCEL_REP) begin
					e_ok = cancel_hit;
				end else if (cmd_q == CMD_COMPLETE && comp_hit) begin
					e_ok = 1'b1; e_id = id_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				phase_q[i] <= PH_FREE;
				rep_q[i]   <= 1'b0;
				cp_q[i]    <= 1'b0;
				gen_q[i]   <= '0;
			end
			tag_q    <= {{(TAG_W-1){1'b0}}, 1'b1};
			scan_q   <= '0;
			pend_v_q <= 1'b0;
			have_q   <= 1'b0;
			done     <= 1'b0;
		end else begin
			done <= emit;
			unique case (ctl.op)
				OP_LOAD: begin
					scan_q   <= '0;
					pend_v_q <= 1'b0;
					have_q   <= 1'b0;
				end
				OP_ADD: begin
					if (alloc) begin
						gen_q[ai]   <= tag_q;
						tag_q       <= (tag_q == TAG_MAX) ? {{(TAG_W-1){1'b0}}, 1'b1}
							: tag_q + 1'b1;
						cp_q[ai]    <= 1'b0;
						rep_q[ai]   <= (cmd_q == CMD_ADD_REP);
						phase_q[ai] <= PH_ARMED;
					end
					scan_q <= scan_q + 1'b1;
				end
				OP_TICK: begin
					if (due) begin
						phase_q[ai] <= PH_FIRING;
						cp_q[ai]    <= 1'b0;
						pend_v_q    <= 1'b1;
					end
					if (earlier)
						have_q <= 1'b1;
					scan_q <= scan_q + 1'b1;
				end
				OP_ONE: begin
					if (cmd_q == CMD_CANCEL_AL || cmd_q == CMD_CANCEL_REP) begin
						if (cancel_hit) begin
							if (c_ph == PH_ARMED)
								phase_q[ai] <= PH_FREE;
							else
								cp_q[ai] <= 1'b1;
						end
					end else if (cmd_q == CMD_COMPLETE && comp_hit) begin
						phase_q[ai] <= (comp_keep && !c_cp) ? PH_ARMED : PH_FREE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD) begin
			cmd_q   <= cmd;
			now_q   <= now_us;
			delay_q <= lead_time;
			id_q    <= timer_ref;
			keep_q  <= keep_going;
			delta_q <= reschedule_delta;
			mag_q   <= magnitude((cmd == CMD_ADD_REP) ? lead_time : reschedule_delta);
		end
		if (alloc) begin
			tgt_q[ai] <= add_tgt;
			per_q[ai] <= mag_q;
		end
		if (ctl.op == OP_ONE && cmd_q == CMD_COMPLETE && comp_hit && comp_keep && !c_cp)
			tgt_q[ai] <= comp_tgt;
		if (ctl.op == OP_TICK) begin
			if (due) begin
				pend_id_q  <= ID_W'({ai, c_gen});
				pend_rep_q <= c_rep;
				pend_tgt_q <= c_tgt;
			end
			if (earlier)
				early_q <= c_tgt;
		end
		if (emit) begin
			ok               <= e_ok;
			result_id        <= e_id;
			fired_repeating  <= e_rep;
			fire_time        <= e_tgt;
			have_deadline    <= e_hd;
			next_deadline_us <= e_nd;
			last             <= e_last;
		end
	end

	a_tag_nz: assert property (@(posedge clk) disable iff (!arst_n)
		tag_q != '0) else $error("generation tag hit zero");
	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_LOAD |=> scan_q == '0) else $error("scan not cleared");
	a_tend_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_TEND |=> done && last) else $error("tick did not close");

endmodule

FILE: hw/rtl/alarm_slot_scheduler.sv
// An add scans for the first free slot, a tick scans every slot, and cancel, complete
// and other commands pass through a single-op state. One transaction at a time: busy
// falls in the cycle that carries the last result, so the next start is taken at the
// edge that takes it.
// A tick issues one result per fired slot, last one at its end, or one if none fired.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Reset (arst_n low, asynchronous): all slots free, generations zero, next tag one.
module alarm_slot_scheduler
	import alss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        cmd,
	input  logic [TIME_W-1:0] now_us,
	input  logic [63:0]       lead_time,
	input  logic [ID_W-1:0]   timer_ref,
	input  logic              keep_going,
	input  logic [63:0]       reschedule_delta,
	output logic              done,
	output logic              ok,
	output logic [ID_W-1:0]   result_id,
	output logic              fired_repeating,
	output logic [TIME_W-1:0] fire_time,
	output logic              have_deadline,
	output logic [TIME_W-1:0] next_deadline_us,
	output logic              last
);

	ctl_t ctl;
	sts_t sts;

	alss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	alss_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.cmd              (cmd),
		.now_us           (now_us),
		.lead_time        (lead_time),
		.timer_ref        (timer_ref),
		.keep_going       (keep_going),
		.reschedule_delta (reschedule_delta),
		.done             (done),
		.ok               (ok),
		.result_id        (result_id),
		.fired_repeating  (fired_repeating),
		.fire_time        (fire_time),
		.have_deadline    (have_deadline),
		.next_deadline_us (next_deadline_us),
		.last             (last)
	);

endmodule
